@@ sv/rsc_pkg.sv @@
// Shared types, constants and helpers of the rotary sine/cosine generator.
// Used by the angle sequencer, the CORDIC cells and the top level.
package rsc_pkg;

  localparam int POSITION_BITS = 24;
  localparam int MAX_HALF_DIM = 64;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 6;
  localparam int SINCOS_ITERATIONS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CELL_COUNT = (SINCOS_ITERATIONS < ATAN_ENTRIES) ?
                              SINCOS_ITERATIONS : ATAN_ENTRIES;
  localparam int CORDIC_W = 34;

  // Register indexes of the configuration channel
  localparam logic [1:0] CFG_FREQ_RATIO = 2'd0;
  localparam logic [1:0] CFG_HALF_DIM = 2'd1;
  localparam logic [1:0] CFG_GAIN = 2'd2;

  localparam logic [31:0] FREQ_RATIO_RESET = 32'd3460884000;
  localparam logic [6:0] HALF_DIM_RESET = 7'd64;
  localparam logic [15:0] GAIN_RESET = 16'd32768;

  // Fixed-point constants
  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
  localparam logic [17:0] TWO_PI_LO = TWO_PI_Q32[17:0];
  localparam logic [16:0] TWO_PI_HI = TWO_PI_Q32[34:18];
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
  localparam logic [31:0] CORDIC_K_Q32 = 32'd2608131496;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

  // Arctangent of 2^-i in Q0.32 turns
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_QUOT,
    ST_QC_LO,
    ST_QC_HI,
    ST_REM,
    ST_FIX,
    ST_TURNS,
    ST_ISSUE
  } state_t;

  typedef struct packed {
    logic [31:0] freq_ratio;
    logic [6:0] half_dim;
    logic [15:0] gain;
  } cfg_t;

  // One pair travelling down the CORDIC chain
  typedef struct packed {
    logic valid;
    logic neg;
    logic last;
    logic [INDEX_W-1:0] idx;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } cordic_word_t;

  // Q.30 to Q2.13, round half up, optional negation, saturate
  function automatic logic [15:0] to_q13(input logic signed [CORDIC_W-1:0] v,
                                         input logic neg);
    logic signed [CORDIC_W:0] a;
    logic signed [CORDIC_W:0] r;
    logic [15:0] res;
    a = neg ? -{v[CORDIC_W-1], v} : {v[CORDIC_W-1], v};
    r = (a + 35'sd65536) >>> 17;
    if (r > 35'sd32767) begin
      res = 16'h7FFF;
    end else if (r < -35'sd32768) begin
      res = 16'h8000;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

endpackage

@@ sv/rsc_cordic_cell.sv @@
// One rotation-mode CORDIC step with its pipeline register.
// Depends on rsc_pkg for the word type and the arctangent table.
module rsc_cordic_cell import rsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [4:0]   step,
  input  cordic_word_t din,
  output cordic_word_t dout
);

  logic signed [CORDIC_W-1:0] dx;
  logic signed [CORDIC_W-1:0] dy;
  logic signed [CORDIC_W-1:0] angle;
  cordic_word_t result;

  // Rotate towards zero residual angle
  always_comb begin
    dx = din.y >>> step;
    dy = din.x >>> step;
    angle = CORDIC_W'(ATAN_TURNS[step]);
    result = din;
    if (!din.z[CORDIC_W-1]) begin
      result.x = din.x - dx;
      result.y = din.y + dy;
      result.z = din.z - angle;
    end else begin
      result.x = din.x + dx;
      result.y = din.y - dy;
      result.z = din.z + angle;
    end
  end

  // Pipeline register; only the valid bit is reset
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.neg <= result.neg;
      dout.last <= result.last;
      dout.idx <= result.idx;
      dout.x <= result.x;
      dout.y <= result.y;
      dout.z <= result.z;
    end
  end

endmodule

@@ sv/rsc_angle_seq.sv @@
// Per-position sequencer: inverse frequency, angle, reduction to turns.
// Depends on rsc_pkg; feeds the first cell of the CORDIC chain.
module rsc_angle_seq import rsc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [POSITION_BITS-1:0] in_position,
  input  logic                     chain_en,
  output cordic_word_t             issue
);

  state_t state, state_next;

  logic [POSITION_BITS-1:0] pos;
  logic [32:0] inv;
  logic [COUNT_W-1:0] idx;
  logic [COUNT_W-1:0] count;
  logic [39:0] p_lo;
  logic [40:0] p_hi;
  logic [47:0] iv_lo;
  logic [48:0] iv_hi;
  logic [56:0] angle;
  logic [21:0] q;
  logic [39:0] m_lo;
  logic [38:0] m_hi;
  logic signed [37:0] rem;
  logic [34:0] red;
  logic [31:0] t;
  logic [CORDIC_W-1:0] x0;

  logic [COUNT_W-1:0] count_eff;
  logic [54:0] quot_prod;
  logic [64:0] inv_sum;
  logic [63:0] turns_sum;
  logic [47:0] gain_prod;
  logic last_pair;
  logic neg;
  logic [31:0] t_adj;

  // Clamp of the pair count
  always_comb begin
    if (cfg.half_dim == '0) begin
      count_eff = COUNT_W'(1);
    end else if (cfg.half_dim > COUNT_W'(MAX_HALF_DIM)) begin
      count_eff = COUNT_W'(MAX_HALF_DIM);
    end else begin
      count_eff = cfg.half_dim;
    end
  end

  // Arithmetic helpers
  always_comb begin
    quot_prod = 55'(angle[56:32]) * 55'(INV_TWO_PI_Q32);
    inv_sum = {iv_hi, 16'b0} + 65'(iv_lo) + 65'h8000_0000;
    turns_sum = 64'(red[34:32]) * 64'(INV_TWO_PI_Q32)
              + ((64'(red[31:0]) * 64'(INV_TWO_PI_Q32) + 64'h8000_0000) >> 32);
    gain_prod = 48'(cfg.gain) * 48'(CORDIC_K_Q32);
    last_pair = (idx + COUNT_W'(1)) == count;
    neg = (t >= QUARTER_TURN) && (t < THREE_QUARTER_TURN);
    t_adj = neg ? (t - HALF_TURN) : t;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_MUL_LO;
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_SUM;
      ST_SUM:    state_next = ST_QUOT;
      ST_QUOT:   state_next = ST_QC_LO;
      ST_QC_LO:  state_next = ST_QC_HI;
      ST_QC_HI:  state_next = ST_REM;
      ST_REM:    state_next = ST_FIX;
      ST_FIX:    state_next = ST_TURNS;
      ST_TURNS:  state_next = ST_ISSUE;
      ST_ISSUE: begin
        if (chain_en) state_next = last_pair ? ST_IDLE : ST_MUL_LO;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    issue.valid = (state == ST_ISSUE) && chain_en;
    issue.neg = neg;
    issue.last = last_pair;
    issue.idx = idx[INDEX_W-1:0];
    issue.x = x0;
    issue.y = '0;
    issue.z = CORDIC_W'($signed(t_adj));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        idx <= '0;
      end else if (state == ST_ISSUE && chain_en) begin
        idx <= last_pair ? '0 : idx + COUNT_W'(1);
      end
    end
  end

  // Datapath, the arithmetic split over the sequencer states
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        pos <= in_position;
        inv <= ONE_Q32;
        count <= count_eff;
      end
      ST_MUL_LO: begin
        p_lo <= 40'(pos) * 40'(inv[15:0]);
        iv_lo <= 48'(inv[15:0]) * 48'(cfg.freq_ratio);
      end
      ST_MUL_HI: begin
        p_hi <= 41'(pos) * 41'(inv[32:16]);
        iv_hi <= 49'(inv[32:16]) * 49'(cfg.freq_ratio);
      end
      ST_SUM: begin
        angle <= 57'({p_hi, 16'b0}) + 57'(p_lo);
        inv <= inv_sum[64:32];
      end
      ST_QUOT:  q <= quot_prod[53:32];
      ST_QC_LO: m_lo <= 40'(q) * 40'(TWO_PI_LO);
      ST_QC_HI: m_hi <= 39'(q) * 39'(TWO_PI_HI);
      ST_REM:   rem <= $signed(angle[37:0] - ({m_hi[19:0], 18'b0} + m_lo[37:0]));
      ST_FIX: begin
        if (rem[37]) begin
          red <= 35'(rem + 38'sd26986075409);
        end else if (rem >= 38'sd26986075409) begin
          red <= 35'(rem - 38'sd26986075409);
        end else begin
          red <= rem[34:0];
        end
      end
      ST_TURNS: begin
        t <= turns_sum[31:0];
        x0 <= CORDIC_W'(gain_prod >> 17);
      end
      default: begin
      end
    endcase
  end

endmodule

@@ sv/rope_sin_cos_generator_unit.sv @@
// Rotary position embedding sine/cosine generator, top level.
// Depends on rsc_pkg, rsc_angle_seq and rsc_cordic_cell.
//
// Usage:
//   s_tvalid/s_tready/s_tdata take one token position per word. For it the
//   block sends half_dim words, clamped to 1..64, on m_*: freq_index, sine
//   and cosine (Q2.13, scaled by gain), with m_tlast on the final pair of the position.
//   cfg_valid/cfg_index/cfg_data write freq_ratio (0), half_dim (1) and
//   gain (2); cfg_ready is always high. Write only while the block is idle.
// Sequencing:
//   The sequencer steps each pair through narrow multiplies for the angle,
//   modulo 2*pi and turns conversion, then issues it once the chain can
//   advance. Each pair then walks a chain of 16 CORDIC cells plus an output
//   register.
// Reset (rst, synchronous) restores the register defaults and empties the
// chain. When the receiver stalls, the whole chain holds and the sequencer
// waits with its next pair; no word is lost.
module rope_sin_cos_generator_unit import rsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // position[23:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // freq_index[5:0], sin_value[21:6], cos_value[37:22], zero
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg;
  logic chain_en;
  cordic_word_t stage [CELL_COUNT+1];

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.freq_ratio <= FREQ_RATIO_RESET;
      cfg.half_dim <= HALF_DIM_RESET;
      cfg.gain <= GAIN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FREQ_RATIO: cfg.freq_ratio <= cfg_data;
        CFG_HALF_DIM:   cfg.half_dim <= cfg_data[6:0];
        CFG_GAIN:       cfg.gain <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Chain moves whenever the output register can take a word
  assign chain_en = !m_tvalid || m_tready;

  rsc_angle_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_position (s_tdata[POSITION_BITS-1:0]),
    .chain_en    (chain_en),
    .issue       (stage[0])
  );

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    rsc_cordic_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (chain_en),
      .step (5'(i)),
      .din  (stage[i]),
      .dout (stage[i+1])
    );
  end

  // Output register with rounding and saturation
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (chain_en) begin
      m_tvalid <= stage[CELL_COUNT].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chain_en) begin
      m_tdata <= {2'b00,
                  to_q13(stage[CELL_COUNT].x, stage[CELL_COUNT].neg),
                  to_q13(stage[CELL_COUNT].y, stage[CELL_COUNT].neg),
                  stage[CELL_COUNT].idx};
      m_tlast <= stage[CELL_COUNT].last;
    end
  end

  // A pair enters the chain only while the chain advances
  assert property (@(posedge clk) disable iff (rst) stage[0].valid |-> chain_en)
    else $error("pair issued into a stalled chain");

  // An accepted position keeps the sequencer busy for at least one pair
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("sequencer took a new position too early");

  // A stalled output holds the valid bit of the last cell of the chain
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tready) |=> $stable(stage[CELL_COUNT].valid))
    else $error("chain moved during an output stall");

endmodule
